>>> src/sjf_pkg.sv
// Shared constants, codes and types of the shortest-job-first scheduler.
package sjf_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int IN_W      = 32;
    localparam int OUT_W     = 24;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_RUNNING = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic capture;
        logic blk_step;
        logic scan_step;
        logic run_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
        logic is_tick;
    } t_sts;

    function automatic logic [3:0] f_sat(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide  = 32'(cnt);
        f_sat = (wide > 32'd15) ? 4'd15 : wide[3:0];
    endfunction

endpackage

>>> src/sjf_ctrl.sv
// Sequencer of the scheduler: block check, slot scan, run step on ticks, result load.
module sjf_ctrl
    import sjf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BLOCK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_BLOCK;
                end
            end
            S_BLOCK: begin
                o_cmd.blk_step = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = i_sts.is_tick ? S_RUN : S_OUT;
                end
            end
            S_RUN: begin
                o_cmd.run_step = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

endmodule

>>> src/sjf_dp.sv
// Datapath of the scheduler: slot table, run state, scan accumulators, result register.
module sjf_dp
    import sjf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_s_axis_tuser,
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    input  logic             i_m_axis_tready,
    output logic             o_m_axis_tvalid,
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    logic [7:0] r_ident  [NUM_SLOTS];
    logic [7:0] r_total  [NUM_SLOTS];
    logic [7:0] r_used   [NUM_SLOTS];
    logic [7:0] r_bpt    [NUM_SLOTS];
    logic [7:0] r_bleft  [NUM_SLOTS];
    logic [1:0] r_status [NUM_SLOTS];

    logic              r_tick, n_tick;
    logic [IN_W-1:0]   r_item, n_item;
    logic              r_run_active, n_run_active;
    logic [SLOT_W-1:0] r_run_slot, n_run_slot;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_found, n_found;
    logic [SLOT_W-1:0] r_best, n_best;
    logic [7:0]        r_best_total, n_best_total;
    logic [CNT_W-1:0]  r_rdy_cnt, n_rdy_cnt;
    logic [CNT_W-1:0]  r_blk_cnt, n_blk_cnt;
    logic              r_blocked_now, n_blocked_now;
    logic              r_placed, n_placed;
    logic              r_ran_valid, n_ran_valid;
    logic [7:0]        r_ran_id, n_ran_id;
    logic              r_finished, n_finished;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out, n_out;

    logic [SLOT_W-1:0] w_addr;
    logic              w_dispatch;
    logic [1:0]        w_st_rd;
    logic [1:0]        w_new_st;
    logic              w_st_we;
    logic [1:0]        w_st;
    logic              w_used_we;
    logic [7:0]        w_used;
    logic              w_bleft_we;
    logic [7:0]        w_bleft;
    logic              w_load_we;
    logic              w_out_free;
    logic [NUM_SLOTS-1:0] w_running;

    assign w_dispatch = !r_run_active && r_found;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        w_addr = r_run_slot;
        if (i_cmd.scan_step) begin
            w_addr = r_idx;
        end else if (i_cmd.run_step && w_dispatch) begin
            w_addr = r_best;
        end
    end

    assign w_st_rd = r_status[w_addr];

    always_comb begin
        n_tick        = r_tick;
        n_item        = r_item;
        n_run_active  = r_run_active;
        n_run_slot    = r_run_slot;
        n_idx         = r_idx;
        n_found       = r_found;
        n_best        = r_best;
        n_best_total  = r_best_total;
        n_rdy_cnt     = r_rdy_cnt;
        n_blk_cnt     = r_blk_cnt;
        n_blocked_now = r_blocked_now;
        n_placed      = r_placed;
        n_ran_valid   = r_ran_valid;
        n_ran_id      = r_ran_id;
        n_finished    = r_finished;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        w_new_st      = w_st_rd;
        w_st_we       = 1'b0;
        w_st          = w_st_rd;
        w_used_we     = 1'b0;
        w_used        = r_used[w_addr] + 8'd1;
        w_bleft_we    = 1'b0;
        w_bleft       = r_bleft[w_addr] - 8'd1;
        w_load_we     = 1'b0;

        if (i_cmd.capture) begin
            n_tick        = i_s_axis_tuser;
            n_item        = i_s_axis_tdata;
            n_idx         = '0;
            n_found       = 1'b0;
            n_placed      = 1'b0;
            n_rdy_cnt     = '0;
            n_blk_cnt     = '0;
            n_blocked_now = 1'b0;
            n_ran_valid   = 1'b0;
            n_ran_id      = '0;
            n_finished    = 1'b0;
        end

        if (i_cmd.blk_step && r_tick == CMD_TICK && r_run_active) begin
            if (w_st_rd != ST_RUNNING) begin
                n_run_active = 1'b0;
            end else if (r_used[w_addr] == r_bpt[w_addr]) begin
                w_st_we       = 1'b1;
                w_st          = ST_BLOCKED;
                n_run_active  = 1'b0;
                n_blocked_now = 1'b1;
            end
        end

        if (i_cmd.scan_step) begin
            if (r_tick == CMD_TICK) begin
                if (w_st_rd == ST_BLOCKED) begin
                    if (r_bleft[w_addr] == 8'd0) begin
                        w_new_st = ST_READY;
                        w_st_we  = 1'b1;
                        w_st     = ST_READY;
                    end else begin
                        w_bleft_we = 1'b1;
                    end
                end
                if (!r_run_active && w_new_st == ST_READY &&
                    (!r_found || r_total[w_addr] < r_best_total)) begin
                    n_found      = 1'b1;
                    n_best       = w_addr;
                    n_best_total = r_total[w_addr];
                end
            end else if (w_st_rd == ST_EMPTY && !r_placed) begin
                w_load_we = 1'b1;
                w_new_st  = ST_READY;
                w_st_we   = 1'b1;
                w_st      = ST_READY;
                n_placed  = 1'b1;
            end
            if (w_new_st == ST_READY) begin
                n_rdy_cnt = r_rdy_cnt + CNT_W'(1);
            end
            if (w_new_st == ST_BLOCKED) begin
                n_blk_cnt = r_blk_cnt + CNT_W'(1);
            end
            n_idx = o_sts.scan_last ? '0 : r_idx + SLOT_W'(1);
        end

        if (i_cmd.run_step && (r_run_active || r_found)) begin
            if (w_dispatch) begin
                n_run_slot = r_best;
                n_rdy_cnt  = r_rdy_cnt - CNT_W'(1);
            end
            n_ran_valid = 1'b1;
            n_ran_id    = r_ident[w_addr];
            w_used_we   = 1'b1;
            w_st_we     = 1'b1;
            if (w_used == r_total[w_addr]) begin
                w_st         = ST_EMPTY;
                n_run_active = 1'b0;
                n_finished   = 1'b1;
            end else begin
                w_st         = ST_RUNNING;
                n_run_active = 1'b1;
            end
        end

        if (i_cmd.out_load) begin
            n_out = {4'd0, (r_tick == CMD_LOAD) && !r_placed, f_sat(r_blk_cnt),
                     f_sat(r_rdy_cnt), r_blocked_now, r_finished, r_ran_id, r_ran_valid};
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            r_ident[w_addr] <= r_item[7:0];
            r_total[w_addr] <= r_item[15:8];
            r_used[w_addr]  <= 8'd0;
            r_bpt[w_addr]   <= r_item[23:16];
            r_bleft[w_addr] <= r_item[31:24];
        end
        if (w_used_we) begin
            r_used[w_addr] <= w_used;
        end
        if (w_bleft_we) begin
            r_bleft[w_addr] <= w_bleft;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_status[i] <= ST_EMPTY;
            end
        end else if (w_st_we) begin
            r_status[w_addr] <= w_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active <= 1'b0;
            r_run_slot   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_run_active <= n_run_active;
            r_run_slot   <= n_run_slot;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick        <= n_tick;
        r_item        <= n_item;
        r_idx         <= n_idx;
        r_found       <= n_found;
        r_best        <= n_best;
        r_best_total  <= n_best_total;
        r_rdy_cnt     <= n_rdy_cnt;
        r_blk_cnt     <= n_blk_cnt;
        r_blocked_now <= n_blocked_now;
        r_placed      <= n_placed;
        r_ran_valid   <= n_ran_valid;
        r_ran_id      <= n_ran_id;
        r_finished    <= n_finished;
        r_out         <= n_out;
    end

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_running[i] = (r_status[i] == ST_RUNNING);
        end
    end

    assign o_sts.scan_last = (r_idx == SLOT_W'(NUM_SLOTS - 1));
    assign o_sts.out_free  = w_out_free;
    assign o_sts.is_tick   = (r_tick == CMD_TICK);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_running))
        else $error("more than one slot running");

    a_run_slot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_active |-> r_status[r_run_slot] == ST_RUNNING)
        else $error("active run slot not in running state");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_axis_tready))
        else $error("result overwritten before taken");

endmodule

>>> src/sjf_process_scheduler_top.sv
// Non-preemptive shortest-job-first scheduler with an eight-slot process table.
// Each item is handled on its own: a load goes through block check, slot scan and
// result load before the next item is accepted, and a tick also through a run step;
// the scan walks the slot table at one slot per cycle. The result sits in an
// output register, so the next item is taken while an earlier result still waits.
module sjf_process_scheduler_top
    import sjf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // command
    input  logic             i_s_axis_tuser,
    // proc_id[7:0], total_time[15:8], block_after[23:16], block_length[31:24]
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // ran_valid[0], ran_id[8:1], finished[9], blocked_now[10], ready_count[14:11],
    // blocked_count[18:15], load_error[19], zero[23:20]
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    sjf_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    sjf_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
